FILE: src/gtb_pkg.sv
// shared types and constants for the goertzel tone bank
package gtb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 19;
    localparam int Q_W         = 48;
    localparam int LEN_W       = 11;
    localparam int IHL_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FIDX_W      = 3;
    localparam int MAG_W       = 16;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int NORM_W      = 30;
    localparam int SHIFT_W     = 5;
    localparam int ACC_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 35;
    localparam int SQRT_STEPS  = 32;
    localparam int STEP_W      = 5;
    localparam int BANK_MAX    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HALF_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE    = 3'd2;

    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = 11'd800;
    localparam logic [IHL_W-1:0] INV_HALF_LEN_RESET = 24'd41943;
    localparam logic signed [COEF_W-1:0] COEF_RESET [BANK_MAX] = '{
        19'sd86680, 19'sd77042, 19'sd69361, 19'sd58587, 19'sd42456
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_LO,
        S_UPD_HI,
        S_UPD_WR,
        S_NLOAD,
        S_NORM,
        S_T,
        S_AA,
        S_BB,
        S_TB,
        S_SQI,
        S_SQ,
        S_SC,
        S_SH,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_LO,
        MUL_HI,
        MUL_T,
        MUL_AA,
        MUL_BB,
        MUL_TB,
        MUL_SCALE
    } t_mul_sel;

    typedef struct packed {
        logic     take_sample;
        t_mul_sel mul_sel;
        logic     lo_capture;
        logic     q_write;
        logic     norm_load;
        logic     norm_shift;
        logic     t_capture;
        logic     acc_load;
        logic     acc_add;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     mag_capture;
        logic     bank_clear;
        logic     count_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic block_end;
        logic norm_fit;
    } t_dp_sts;

endpackage

FILE: src/goertzel_tone_bank.sv
// goertzel tone bank: one sample request updates all resonators in turn, each via low, high and write steps
// at block end each filter's magnitude is computed, then held until the output is accepted:
// up to 18 normalize shifts, 5 shared-multiplier steps, 32 square-root steps
// one sample in flight at a time; the single shared 33x33 multiplier sets the update rate
// synchronous active-low reset restores register defaults and clears resonators and counter
module goertzel_tone_bank #(
    parameter int NUM_FILTERS      = 5,
    parameter int MAX_BLOCK_LENGTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [gtb_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [gtb_pkg::FIDX_W-1:0]           o_filter_index,
    output logic [gtb_pkg::MAG_W-1:0]            o_magnitude,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gtb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gtb_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import gtb_pkg::*;

    localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    t_dp_cmd        cmd;
    t_dp_sts        sts;
    logic [FW-1:0]  filt;

    assign o_cfg_ready = 1'b1;

    gtb_controller #(
        .NUM_FILTERS (NUM_FILTERS),
        .FW          (FW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_filt  (filt)
    );

    gtb_datapath #(
        .NUM_FILTERS      (NUM_FILTERS),
        .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
        .FW               (FW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_filt         (filt),
        .o_sts          (sts),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_filter_index (o_filter_index),
        .o_magnitude    (o_magnitude),
        .o_last         (o_last)
    );

endmodule

FILE: src/gtb_datapath.sv
// resonator bank, shared multiplier, normalizer, square root and scaling
module gtb_datapath #(
    parameter int NUM_FILTERS      = 5,
    parameter int MAX_BLOCK_LENGTH = 1024,
    parameter int FW               = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gtb_pkg::t_dp_cmd                      i_cmd,
    input  logic [FW-1:0]                         i_filt,
    output gtb_pkg::t_dp_sts                      o_sts,
    input  logic signed [gtb_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_cfg_we,
    input  logic [gtb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gtb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [gtb_pkg::FIDX_W-1:0]            o_filter_index,
    output logic [gtb_pkg::MAG_W-1:0]             o_magnitude,
    output logic                                  o_last
);
    import gtb_pkg::*;

    localparam int CW_RAW = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int CW     = (CW_RAW > LEN_W) ? CW_RAW : LEN_W;

    // configuration
    logic [LEN_W-1:0]              r_block_length;
    logic [IHL_W-1:0]              r_ihl;
    logic signed [COEF_W-1:0]      r_coef [NUM_FILTERS];
    logic [CFG_IDX_W-1:0]          coef_idx;

    // resonators
    logic signed [Q_W-1:0]         r_q1 [NUM_FILTERS];
    logic signed [Q_W-1:0]         r_q2 [NUM_FILTERS];
    logic [CW-1:0]                 r_count;

    logic signed [SAMPLE_W-1:0]    r_x;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [27:0]            r_lo;
    logic signed [Q_W-1:0]         r_a;
    logic signed [Q_W-1:0]         r_b;
    logic [SHIFT_W-1:0]            r_s;
    logic signed [MUL_W-1:0]       r_t;
    logic signed [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]              r_rad;
    logic [REM_W-1:0]              r_rem;
    logic [ROOT_W-1:0]             r_root;
    logic [MAG_W-1:0]              r_mag;
    logic [FIDX_W-1:0]             r_oidx;
    logic                          r_olast;

    logic signed [COEF_W-1:0]      coef_cur;
    logic signed [Q_W-1:0]         q1_cur;
    logic signed [Q_W-1:0]         q2_cur;
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]      rnd_sum;
    logic signed [23:0]            x_sc;
    logic signed [53:0]            q_sum;
    logic signed [Q_W-1:0]         q_sat;
    logic signed [ACC_W-1:0]       p_val;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              trial;
    logic [5:0]                    shamt;
    logic [55:0]                   scaled;
    logic [CW-1:0]                 len;
    logic [CW:0]                   count_next;

    assign coef_cur = r_coef[i_filt];
    assign q1_cur   = r_q1[i_filt];
    assign q2_cur   = r_q2[i_filt];
    assign coef_idx = i_cfg_index - CFG_COEF_BASE;

    // block length of zero or beyond the maximum means the maximum
    always_comb begin
        if (r_block_length == '0 || CW'(r_block_length) > CW'(MAX_BLOCK_LENGTH)) begin
            len = CW'(MAX_BLOCK_LENGTH);
        end else begin
            len = CW'(r_block_length);
        end
        count_next = {1'b0, r_count} + 1'b1;
    end

    assign o_sts.block_end = (count_next >= {1'b0, len});
    assign o_sts.norm_fit  = (r_a[Q_W-1:NORM_W-1] == {(Q_W-NORM_W+1){r_a[Q_W-1]}}) &&
                             (r_b[Q_W-1:NORM_W-1] == {(Q_W-NORM_W+1){r_b[Q_W-1]}});

    // shared multiplier operand select
    always_comb begin
        mul_a = MUL_W'(coef_cur);
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_LO: mul_b = {9'b0, q1_cur[23:0]};
            MUL_HI: mul_b = MUL_W'($signed(q1_cur[Q_W-1:24]));
            MUL_T:  mul_b = MUL_W'($signed(r_a[NORM_W-1:0]));
            MUL_AA: begin
                mul_a = MUL_W'($signed(r_a[NORM_W-1:0]));
                mul_b = MUL_W'($signed(r_a[NORM_W-1:0]));
            end
            MUL_BB: begin
                mul_a = MUL_W'($signed(r_b[NORM_W-1:0]));
                mul_b = MUL_W'($signed(r_b[NORM_W-1:0]));
            end
            MUL_TB: begin
                mul_a = r_t;
                mul_b = MUL_W'($signed(r_b[NORM_W-1:0]));
            end
            MUL_SCALE: begin
                mul_a = {1'b0, r_root};
                mul_b = {9'b0, r_ihl};
            end
            default: mul_b = '0;
        endcase
    end

    // resonator update, rounding and saturation; square-root and scaling terms
    always_comb begin
        rnd_sum = r_prod + PROD_W'(32768);
        x_sc    = {r_x, 8'b0};
        q_sum   = $signed({r_prod[45:0], 8'b0}) + 54'(r_lo) - 54'(q2_cur) + 54'(x_sc);
        if (q_sum[53:Q_W-1] == {(54-Q_W+1){q_sum[53]}}) begin
            q_sat = q_sum[Q_W-1:0];
        end else if (q_sum[53]) begin
            q_sat = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
        p_val  = r_acc - r_prod[ACC_W-1:0];
        rem_sh = {r_rem[REM_W-3:0], r_rad[ACC_W-1:ACC_W-2]};
        trial  = {1'b0, r_root, 2'b01};
        shamt  = 6'd32 - {1'b0, r_s};
        scaled = r_prod[55:0] >> shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RESET;
            r_ihl          <= INV_HALF_LEN_RESET;
            for (int i = 0; i < NUM_FILTERS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BLOCK_LENGTH) begin
                r_block_length <= i_cfg_data[LEN_W-1:0];
            end else if (i_cfg_index == CFG_INV_HALF_LEN) begin
                r_ihl <= i_cfg_data[IHL_W-1:0];
            end else if (i_cfg_index >= CFG_COEF_BASE && 32'(coef_idx) < NUM_FILTERS) begin
                r_coef[coef_idx[FW-1:0]] <= i_cfg_data[COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FILTERS; i++) begin
                r_q1[i] <= '0;
                r_q2[i] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.bank_clear) begin
            for (int i = 0; i < NUM_FILTERS; i++) begin
                r_q1[i] <= '0;
                r_q2[i] <= '0;
            end
            r_count <= '0;
        end else begin
            if (i_cmd.q_write) begin
                r_q2[i_filt] <= q1_cur;
                r_q1[i_filt] <= q_sat;
            end
            if (i_cmd.count_inc) begin
                r_count <= count_next[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_cmd.take_sample) begin
            r_x <= i_sample;
        end
        if (i_cmd.lo_capture) begin
            r_lo <= rnd_sum[43:16];
        end
        if (i_cmd.norm_load) begin
            r_a <= q1_cur;
            r_b <= q2_cur;
            r_s <= '0;
        end else if (i_cmd.norm_shift) begin
            r_a <= r_a >>> 1;
            r_b <= r_b >>> 1;
            r_s <= r_s + 1'b1;
        end
        if (i_cmd.t_capture) begin
            r_t <= rnd_sum[48:16];
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod[ACC_W-1:0];
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
        // one result bit per step, two radicand bits per step
        if (i_cmd.sqrt_load) begin
            r_rad  <= p_val[ACC_W-1] ? '0 : p_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[ACC_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mag_capture) begin
            r_mag   <= (scaled[55:MAG_W] != '0) ? {MAG_W{1'b1}} : scaled[MAG_W-1:0];
            r_oidx  <= FIDX_W'(i_filt);
            r_olast <= (32'(i_filt) == NUM_FILTERS - 1);
        end
    end

    assign o_filter_index = r_oidx;
    assign o_magnitude    = r_mag;
    assign o_last         = r_olast;

endmodule

FILE: src/gtb_controller.sv
// sequencer for resonator updates and per-filter magnitude readout
module gtb_controller #(
    parameter int NUM_FILTERS = 5,
    parameter int FW          = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  gtb_pkg::t_dp_sts  i_sts,
    output gtb_pkg::t_dp_cmd  o_cmd,
    output logic [FW-1:0]     o_filt
);
    import gtb_pkg::*;

    t_state              r_state, n_state;
    logic [FW-1:0]       r_filt, n_filt;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                filt_last;

    assign filt_last = (32'(r_filt) == NUM_FILTERS - 1);
    assign o_filt    = r_filt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_filt  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_filt  <= n_filt;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_filt  = r_filt;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_LO;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take_sample = 1'b1;
                    n_filt  = '0;
                    n_state = S_UPD_LO;
                end
            end
            S_UPD_LO: begin
                o_cmd.mul_sel = MUL_LO;
                n_state = S_UPD_HI;
            end
            S_UPD_HI: begin
                o_cmd.mul_sel    = MUL_HI;
                o_cmd.lo_capture = 1'b1;
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.q_write = 1'b1;
                if (!filt_last) begin
                    n_filt  = r_filt + 1'b1;
                    n_state = S_UPD_LO;
                end else if (i_sts.block_end) begin
                    n_filt  = '0;
                    n_state = S_NLOAD;
                end else begin
                    o_cmd.count_inc = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NLOAD: begin
                o_cmd.norm_load = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_fit) begin
                    n_state = S_T;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_T: begin
                o_cmd.mul_sel = MUL_T;
                n_state = S_AA;
            end
            S_AA: begin
                o_cmd.mul_sel   = MUL_AA;
                o_cmd.t_capture = 1'b1;
                n_state = S_BB;
            end
            S_BB: begin
                o_cmd.mul_sel  = MUL_BB;
                o_cmd.acc_load = 1'b1;
                n_state = S_TB;
            end
            S_TB: begin
                o_cmd.mul_sel = MUL_TB;
                o_cmd.acc_add = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_load = 1'b1;
                n_step  = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 1'b1;
                if (32'(r_step) == SQRT_STEPS - 1) begin
                    n_state = S_SC;
                end
            end
            S_SC: begin
                o_cmd.mul_sel = MUL_SCALE;
                n_state = S_SH;
            end
            S_SH: begin
                o_cmd.mag_capture = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (filt_last) begin
                        o_cmd.bank_clear = 1'b1;
                        n_filt  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_filt  = r_filt + 1'b1;
                        n_state = S_NLOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
